@@ design/radar_target_frame_deframer_assert.svh @@
// ----------------------------------------------------------------------------
// radar target frame deframer assertion macros
// Property shorthands shared by the deframer's checks.
// ----------------------------------------------------------------------------
`ifndef RADAR_TARGET_FRAME_DEFRAMER_ASSERT_SVH
`define RADAR_TARGET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled in reset
`define RFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ design/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rfd_pkg
// Types, constants and helpers shared by the radar target frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

    // frame layout
    localparam int HEAD_LEN = 4;
    localparam int SLOT_LEN = 8;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAIL   = 4'd1;
    localparam logic [31:0] HEADER_RESET = 32'd262058;
    localparam logic [15:0] TAIL_RESET   = 16'd52309;

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 72;

    // sign-magnitude fields
    localparam logic [15:0] SM_MAG  = 16'h7FFF;
    localparam logic [15:0] SM_SIGN = 16'h8000;

    // one decoded target
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] speed;
        logic        [15:0] res;
    } target_t;

    // frame handoff from framer to decoder
    typedef struct packed {
        logic start;
        logic bank;
    } frame_hand_t;

    // decoder sequencer
    typedef enum logic [2:0] {
        DEC_IDLE = 3'b001,
        DEC_READ = 3'b010,
        DEC_EMIT = 3'b100
    } dec_state_t;

    // sign-magnitude to two's complement, negative zero becomes zero
    function automatic logic [15:0] sm_decode(input logic [15:0] raw);
        logic [15:0] mag;
        mag = raw & SM_MAG;
        if ((raw & SM_SIGN) != 16'd0) begin
            mag = 16'd0 - mag;
        end
        return mag;
    endfunction

endpackage

@@ design/radar_target_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// radar_target_frame_deframer
// Fixed-length frame deframer with header and tail sync for a radar sensor
// byte stream; decodes each good frame into one result per target slot.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_*       in         received bytes, one per transaction
//  m_*       out        decoded targets, tlast on the final slot of a frame
//  cfg_*     in         header and tail pattern writes
//
//  One byte is accepted per cycle. A frame store of two banks in one RAM lets
//  a new frame fill while the previous one is decoded: the decoder reads one
//  target byte per cycle, then loads one result per cycle into the output
//  register while the receiver is ready; the first result leaves once all
//  target bytes are read. The final byte of the next frame stalls until the
//  previous frame's last result is loaded into the output register. Reset
//  is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "radar_target_frame_deframer_assert.svh"

module radar_target_frame_deframer #(
    parameter int TARGET_SLOTS = 3,
    parameter int FRAME_BYTES  = 30
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rfd_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] target_index, [17:2] target_x, [33:18] target_y,
    // [49:34] target_speed, [65:50] target_resolution, [67:66] active_count
    output logic [rfd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast    // last
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam int DEPTH = 2 ** (IDX_W + 1);

    logic                 wr_en;
    logic [IDX_W:0]       wr_addr;
    logic [7:0]           wr_data;
    logic [IDX_W:0]       rd_addr;
    logic [7:0]           rd_data;
    logic                 dec_busy;
    rfd_pkg::frame_hand_t hand;

    // sync, index and tail check
    rfd_framer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .dec_busy  (dec_busy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .hand      (hand)
    );

    // two-bank frame store
    rfd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // target decode and result output
    rfd_decoder #(
        .TARGET_SLOTS (TARGET_SLOTS),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_decoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hand     (hand),
        .dec_busy (dec_busy),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a frame is handed over only to an idle decoder
    `RFD_ASSERT_NOW(a_hand_idle, aclk, aresetn, hand.start, !dec_busy)
    // the decoder takes up every handed frame
    `RFD_ASSERT_NEXT(a_hand_taken, aclk, aresetn, hand.start, dec_busy)
    // the input stalls only on the final byte while decoding
    `RFD_ASSERT_NOW(a_stall_busy, aclk, aresetn, !s_tready, dec_busy)

endmodule

@@ design/rfd_ram.sv @@
// ----------------------------------------------------------------------------
// rfd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/rfd_framer.sv @@
// ----------------------------------------------------------------------------
// rfd_framer
// Byte index, header sync and tail check; writes bytes into the frame store
// bank being filled and hands a good frame over to the decoder.
// ----------------------------------------------------------------------------
module rfd_framer #(
    parameter int FRAME_BYTES = 30
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rfd_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                dec_busy,
    output logic                                wr_en,
    output logic [$clog2(FRAME_BYTES):0]        wr_addr,
    output logic [7:0]                          wr_data,
    output rfd_pkg::frame_hand_t                hand
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] HEAD_END = IDX_W'(rfd_pkg::HEAD_LEN);

    logic [31:0]      header_reg;
    logic [15:0]      tail_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             bank_reg, bank_next;
    logic [7:0]       prev_reg;

    logic [31:0] hdr_shift;
    logic        accept;
    logic        head_bad;
    logic        at_end;
    logic        tail_ok;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= rfd_pkg::HEADER_RESET;
            tail_reg   <= rfd_pkg::TAIL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rfd_pkg::CFG_HEADER: header_reg <= cfg_wdata;
                rfd_pkg::CFG_TAIL:   tail_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // header byte expected at this index
    assign hdr_shift = header_reg >> {idx_reg[1:0], 3'b000};

    assign accept   = s_tvalid && s_tready;
    assign head_bad = (idx_reg < HEAD_END) && (s_tdata != hdr_shift[7:0]);
    assign at_end   = (idx_reg == LAST_IDX);
    assign tail_ok  = ({s_tdata, prev_reg} == tail_reg);

    // the final byte waits while the other bank is still being decoded
    assign s_tready = !(at_end && dec_busy);

    // frame store write
    assign wr_en   = accept && !head_bad;
    assign wr_addr = {bank_reg, idx_reg};
    assign wr_data = s_tdata;

    // handoff of a complete frame with a good tail
    assign hand.start = wr_en && at_end && tail_ok;
    assign hand.bank  = bank_reg;

    // index and bank update
    always_comb begin
        idx_next  = idx_reg;
        bank_next = bank_reg;
        if (accept) begin
            if (head_bad || at_end) begin
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
            if (hand.start) begin
                bank_next = !bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            bank_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            bank_reg <= bank_next;
        end
    end

    // previous stored byte, first half of the tail
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prev_reg <= s_tdata;
        end
    end

endmodule

@@ design/rfd_decoder.sv @@
// ----------------------------------------------------------------------------
// rfd_decoder
// Reads the target bytes of a handed-over frame one per cycle, assembles
// and decodes each slot, counts active targets and emits one result each.
// ----------------------------------------------------------------------------
module rfd_decoder #(
    parameter int TARGET_SLOTS = 3,
    parameter int FRAME_BYTES  = 30
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rfd_pkg::frame_hand_t               hand,
    output logic                               dec_busy,
    output logic [$clog2(FRAME_BYTES):0]       rd_addr,
    input  logic [7:0]                         rd_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rfd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    localparam int IDX_W  = $clog2(FRAME_BYTES);
    localparam int POS_W  = $clog2(rfd_pkg::SLOT_LEN * TARGET_SLOTS);
    localparam int SLOT_W = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int ABS_W  = $clog2(FRAME_BYTES + rfd_pkg::HEAD_LEN +
                                   rfd_pkg::SLOT_LEN * TARGET_SLOTS);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(rfd_pkg::SLOT_LEN * TARGET_SLOTS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TARGET_SLOTS - 1);
    localparam logic [ABS_W-1:0]  HEAD_OFS  = ABS_W'(rfd_pkg::HEAD_LEN);
    localparam logic [ABS_W-1:0]  FRAME_END = ABS_W'(FRAME_BYTES);

    rfd_pkg::dec_state_t state_reg, state_next;
    logic              bank_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              issue_done_reg;
    logic              rd_valid_reg;
    logic [POS_W-1:0]  rd_pos_reg;
    logic              rd_inrange_reg;
    logic [55:0]       sr_reg;
    logic [1:0]        active_reg;
    logic [SLOT_W-1:0] emit_slot_reg;
    rfd_pkg::target_t  slot_reg [TARGET_SLOTS];
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [rfd_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [ABS_W-1:0]  abs_pos;
    logic              issue;
    logic [7:0]        rd_byte;
    logic [63:0]       word;
    logic              slot_done;
    logic [SLOT_W-1:0] wr_slot;
    rfd_pkg::target_t  dec_tgt;
    logic              dec_nz;
    logic              out_load;
    logic [3:0]        emit_ext;
    rfd_pkg::target_t  emit_tgt;

    assign dec_busy = (state_reg != rfd_pkg::DEC_IDLE);

    // read address of the next target byte
    assign abs_pos = HEAD_OFS + ABS_W'(pos_reg);
    assign rd_addr = {bank_reg, abs_pos[IDX_W-1:0]};
    assign issue   = (state_reg == rfd_pkg::DEC_READ) && !issue_done_reg;

    // returned byte, zero past the end of the frame
    assign rd_byte   = rd_inrange_reg ? rd_data : 8'd0;
    assign word      = {rd_byte, sr_reg};
    assign slot_done = rd_valid_reg && (rd_pos_reg[2:0] == 3'd7);
    assign wr_slot   = SLOT_W'(rd_pos_reg >> 3);

    // slot decode
    always_comb begin
        dec_tgt.x     = rfd_pkg::sm_decode(word[15:0]);
        dec_tgt.y     = rfd_pkg::sm_decode(word[31:16]);
        dec_tgt.speed = rfd_pkg::sm_decode(word[47:32]);
        dec_tgt.res   = word[63:48];
        dec_nz = (dec_tgt.x != 16'sd0) || (dec_tgt.y != 16'sd0) || (dec_tgt.speed != 16'sd0);
    end

    // output register is free or drains this cycle
    assign out_load = (state_reg == rfd_pkg::DEC_EMIT) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rfd_pkg::DEC_IDLE: begin
                if (hand.start) begin
                    state_next = rfd_pkg::DEC_READ;
                end
            end
            rfd_pkg::DEC_READ: begin
                if (rd_valid_reg && (rd_pos_reg == LAST_POS)) begin
                    state_next = rfd_pkg::DEC_EMIT;
                end
            end
            rfd_pkg::DEC_EMIT: begin
                if (out_load && (emit_slot_reg == LAST_SLOT)) begin
                    state_next = rfd_pkg::DEC_IDLE;
                end
            end
            default: state_next = rfd_pkg::DEC_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rfd_pkg::DEC_IDLE;
            pos_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            active_reg     <= 2'd0;
            emit_slot_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            // read issue counter
            if (hand.start && !dec_busy) begin
                pos_reg        <= '0;
                issue_done_reg <= 1'b0;
                active_reg     <= 2'd0;
                emit_slot_reg  <= '0;
            end else begin
                if (issue) begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == LAST_POS) begin
                        issue_done_reg <= 1'b1;
                    end
                end
                // active target count, saturating
                if (slot_done && dec_nz && (active_reg != 2'd3)) begin
                    active_reg <= active_reg + 2'd1;
                end
                if (out_load) begin
                    emit_slot_reg <= emit_slot_reg + 1'b1;
                end
            end
            // output valid
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // read pipeline and slot assembly
    always_ff @(posedge aclk) begin
        if (hand.start && !dec_busy) begin
            bank_reg <= hand.bank;
        end
        rd_pos_reg     <= pos_reg;
        rd_inrange_reg <= (abs_pos < FRAME_END);
        if (rd_valid_reg) begin
            sr_reg <= word[63:8];
        end
        if (slot_done) begin
            slot_reg[wr_slot] <= dec_tgt;
        end
    end

    // result packing
    assign emit_ext = 4'(emit_slot_reg);
    assign emit_tgt = slot_reg[emit_slot_reg];

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {4'd0, active_reg, emit_tgt.res, emit_tgt.speed,
                             emit_tgt.y, emit_tgt.x, emit_ext[1:0]};
            out_last_reg <= (emit_slot_reg == LAST_SLOT);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
